/* rtl/core/prct_pkg.sv */
// Package for the page range coalescing table: widths, status codes, entry type.
package prct_pkg;

    localparam int MAX_RANGES_DEF = 16;

    localparam int ADDR_W   = 48;
    localparam int LKUP_W   = 47;
    localparam int PG_SHIFT = 12;
    localparam int PG_W     = ADDR_W - PG_SHIFT;
    localparam int STAT_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERLAP   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS      = 3'd4;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic [PG_W-1:0] start_pg;
        logic [PG_W-1:0] end_pg;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* rtl/core/prct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module prct_ram #(
    parameter int WIDTH = prct_pkg::ENTRY_W,
    parameter int DEPTH = prct_pkg::MAX_RANGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/page_range_coalescing_table.sv */
// Top level of the page range coalescing table: request sequencer around the entry RAM.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  request  | in        | start && !busy     | i_req_type, i_range_lo, i_range_hi,
//           |           |                    | i_lookup_addr
//  result   | out       | o_valid, one cycle | o_status, o_slot, o_entry_lo, o_entry_hi,
//           |           |                    | o_entry_count
//
// One transaction at a time. A malformed add answers in the cycle after acceptance.
// A lookup walks the entries through the RAM read port, one per cycle. An add does an
// overlap pass, then an adjacency pass that restarts from slot 0 after each merge; after
// a merge is seen, the last entry is read and then written into the freed slot.
// The single RAM read port sets the pace. The result appears in the cycle busy falls.
// Reset (synchronous, active low) empties the table; entries need no clearing since only
// slots below the count are ever read. The receiver cannot stall: o_valid is a strobe.
module page_range_coalescing_table #(
    parameter int MAX_RANGES = prct_pkg::MAX_RANGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_req_type,
    input  logic [prct_pkg::ADDR_W-1:0]         i_range_lo,
    input  logic [prct_pkg::ADDR_W-1:0]         i_range_hi,
    input  logic [prct_pkg::LKUP_W-1:0]         i_lookup_addr,
    output logic                                o_valid,
    output logic [prct_pkg::STAT_W-1:0]         o_status,
    output logic [prct_pkg::SLOT_W-1:0]         o_slot,
    output logic [prct_pkg::ADDR_W-1:0]         o_entry_lo,
    output logic [prct_pkg::ADDR_W-1:0]         o_entry_hi,
    output logic [prct_pkg::CNT_W-1:0]          o_entry_count
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int PW = prct_pkg::PG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OVL  = 3'd1;   // overlap pass
    localparam logic [2:0] S_MRG  = 3'd2;   // adjacency pass
    localparam logic [2:0] S_MVRD = 3'd3;   // read last entry
    localparam logic [2:0] S_MVWR = 3'd4;   // move it into the freed slot
    localparam logic [2:0] S_LKP  = 3'd5;   // lookup pass

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx,   n_idx;     // next slot to read
    logic                          r_pv,    n_pv;      // read data in flight
    logic [IW-1:0]                 r_pidx,  n_pidx;    // slot of read data
    logic [IW-1:0]                 r_hit,   n_hit;     // slot being freed by a merge
    logic [PW-1:0]                 r_lp,    n_lp;      // low page, or lookup page
    logic [PW-1:0]                 r_hp,    n_hp;
    logic                          r_valid, n_valid;
    logic [prct_pkg::STAT_W-1:0]   r_status, n_status;
    logic [prct_pkg::SLOT_W-1:0]   r_slot,  n_slot;
    logic [PW-1:0]                 r_olo,   n_olo;
    logic [PW-1:0]                 r_ohi,   n_ohi;

    logic                          we;
    logic [IW-1:0]                 waddr;
    prct_pkg::t_entry              wdata;
    logic [IW-1:0]                 raddr;
    prct_pkg::t_entry              rd;

    logic                          issue;
    logic                          scan_done;
    logic [CW-1:0]                 last;
    logic                          malformed;

    prct_ram #(
        .WIDTH (prct_pkg::ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign issue     = (r_idx < r_count);
    assign scan_done = !r_pv && !issue;
    assign last      = r_count - CW'(1);
    assign malformed = (i_range_lo >= i_range_hi)
                    || (i_range_lo[prct_pkg::PG_SHIFT-1:0] != '0)
                    || (i_range_hi[prct_pkg::PG_SHIFT-1:0] != '0);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pv     = 1'b0;
        n_pidx   = r_pidx;
        n_hit    = r_hit;
        n_lp     = r_lp;
        n_hp     = r_hp;
        n_valid  = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        n_olo    = r_olo;
        n_ohi    = r_ohi;
        we       = 1'b0;
        waddr    = r_hit;
        wdata    = rd;
        raddr    = r_idx[IW-1:0];

        // scan passes share the pipelined read: issue one slot per cycle
        if ((r_state == S_OVL || r_state == S_MRG || r_state == S_LKP) && issue) begin
            n_idx  = r_idx + CW'(1);
            n_pv   = 1'b1;
            n_pidx = r_idx[IW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx = '0;
                    if (i_req_type == prct_pkg::REQ_LOOKUP) begin
                        n_lp    = PW'(i_lookup_addr >> prct_pkg::PG_SHIFT);
                        n_state = S_LKP;
                    end else if (malformed) begin
                        n_valid  = 1'b1;
                        n_status = prct_pkg::ST_MALFORMED;
                        n_slot   = '0;
                        n_olo    = '0;
                        n_ohi    = '0;
                    end else begin
                        n_lp    = i_range_lo[prct_pkg::ADDR_W-1:prct_pkg::PG_SHIFT];
                        n_hp    = i_range_hi[prct_pkg::ADDR_W-1:prct_pkg::PG_SHIFT];
                        n_state = S_OVL;
                    end
                end
            end
            S_OVL: begin
                if (r_pv && (r_lp < rd.end_pg) && (r_hp > rd.start_pg)) begin
                    n_valid  = 1'b1;
                    n_status = prct_pkg::ST_OVERLAP;
                    n_slot   = '0;
                    n_olo    = '0;
                    n_ohi    = '0;
                    n_pv     = 1'b0;
                    n_state  = S_IDLE;
                end else if (scan_done) begin
                    n_idx   = '0;
                    n_state = S_MRG;
                end
            end
            S_MRG: begin
                if (r_pv && ((r_hp == rd.start_pg) || (r_lp == rd.end_pg))) begin
                    n_lp    = (rd.start_pg < r_lp) ? rd.start_pg : r_lp;
                    n_hp    = (rd.end_pg > r_hp) ? rd.end_pg : r_hp;
                    n_hit   = r_pidx;
                    n_pv    = 1'b0;
                    n_state = S_MVRD;
                end else if (scan_done) begin
                    n_valid = 1'b1;
                    if (r_count >= CW'(MAX_RANGES)) begin
                        n_status = prct_pkg::ST_FULL;
                        n_slot   = '0;
                        n_olo    = '0;
                        n_ohi    = '0;
                    end else begin
                        we       = 1'b1;
                        waddr    = r_count[IW-1:0];
                        wdata    = '{start_pg: r_lp, end_pg: r_hp};
                        n_count  = r_count + CW'(1);
                        n_status = prct_pkg::ST_OK;
                        n_slot   = prct_pkg::SLOT_W'(r_count);
                        n_olo    = r_lp;
                        n_ohi    = r_hp;
                    end
                    n_state = S_IDLE;
                end
            end
            S_MVRD: begin
                raddr   = last[IW-1:0];
                n_state = S_MVWR;
            end
            S_MVWR: begin
                // last entry fills the freed slot; restart next cycle so the
                // read never meets this write
                we      = 1'b1;
                waddr   = r_hit;
                wdata   = rd;
                n_count = last;
                n_idx   = '0;
                n_state = S_MRG;
            end
            S_LKP: begin
                if (r_pv && (r_lp >= rd.start_pg) && (r_lp < rd.end_pg)) begin
                    n_valid  = 1'b1;
                    n_status = prct_pkg::ST_OK;
                    n_slot   = prct_pkg::SLOT_W'(r_pidx);
                    n_olo    = rd.start_pg;
                    n_ohi    = rd.end_pg;
                    n_pv     = 1'b0;
                    n_state  = S_IDLE;
                end else if (scan_done) begin
                    n_valid  = 1'b1;
                    n_status = prct_pkg::ST_MISS;
                    n_slot   = '0;
                    n_olo    = '0;
                    n_ohi    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_valid <= n_valid;
        end
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_lp     <= n_lp;
        r_hp     <= n_hp;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_olo    <= n_olo;
        r_ohi    <= n_ohi;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_lo    = {r_olo, {prct_pkg::PG_SHIFT{1'b0}}};
    assign o_entry_hi    = {r_ohi, {prct_pkg::PG_SHIFT{1'b0}}};
    assign o_entry_count = prct_pkg::CNT_W'(r_count);

    // result strobe only once the sequencer has returned to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // table never holds more entries than slots
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("entry count beyond table size");

    // an accepted transaction either works on or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction dropped");

    // a freed slot always lies inside the table
    a_move_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVWR) |-> (CW'(r_hit) < r_count))
        else $error("merge frees a slot beyond the count");

    // a merge always shrinks the table by one
    a_move_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVWR) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("merge did not remove an entry");

endmodule
